[src/cfsr_pkg.sv]
`default_nettype none

package cfsr_pkg;

  // Datapath width of the CORDIC x/y words (signed). Normalized input stays
  // below 2^25 and the seed adds a 23-bit constant, so 29 bits leave headroom.
  localparam int unsigned CordW = 29;

  // Seed offset for the hyperbolic vectoring pass.
  localparam logic signed [CordW-1:0] RootMagic = CordW'(32'h005D50AD);

  localparam int unsigned NumSteps = 7;

  // Per-step hyperbolic shift; shift 4 is repeated for convergence.
  function automatic logic [2:0] step_shift(input int unsigned k);
    logic [2:0] s;
    unique case (k)
      0:       s = 3'd1;
      1:       s = 3'd2;
      2:       s = 3'd3;
      3:       s = 3'd4;
      4:       s = 3'd4;
      5:       s = 3'd5;
      default: s = 3'd6;
    endcase
    return s;
  endfunction

  // Leading zeros of {1'b0, v} in a 32-bit word; meaningful for v != 0.
  function automatic logic [4:0] lead_zeros(input logic [30:0] v);
    logic [4:0] n;
    n = 5'd31;
    for (int i = 0; i < 31; i++) begin
      if (v[i]) begin
        n = 5'(31 - i);
      end
    end
    return n;
  endfunction

  // One beat in flight through the CORDIC stages.
  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [4:0]       half;   // half of the even normalizing shift
    logic                    zero;   // input was zero, force result to 0
  } cfsr_vec_t;

endpackage

`default_nettype wire

[src/cfsr_step.sv]
`default_nettype none

module cfsr_step
  import cfsr_pkg::*;
#(
  parameter int unsigned SHIFT = 1
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             ld,
  input  wire             vin,
  input  wire cfsr_vec_t  din,
  output logic            vout,
  output cfsr_vec_t       dout
);

  logic signed [CordW-1:0] xs;
  logic signed [CordW-1:0] ys;
  cfsr_vec_t               dout_next;

  always_comb begin
    xs = din.x >>> SHIFT;
    ys = din.y >>> SHIFT;
    dout_next = din;
    // rotate toward y = 0; both updates use the old x and y
    if (!din.y[CordW-1]) begin
      dout_next.x = din.x - ys;
      dout_next.y = din.y - xs;
    end else begin
      dout_next.x = din.x + ys;
      dout_next.y = din.y + xs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (ld) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      dout <= dout_next;
    end
  end

endmodule

`default_nettype wire

[src/cordic_fixed_square_root.sv]
// Square root, 12 fraction bits in and out, by hyperbolic CORDIC vectoring.
// Pipeline: one stage for the leading-zero count, one for normalize/seed,
//   seven CORDIC steps and one output stage.
// Throughput: one beat per cycle unless out_ready stalls the output; each stage holds its beat only when the
//   stage after it is full and stalled, so bubbles are squeezed out.
// Reset (rst, synchronous): clears all stage valid bits; datapath is not reset.
`default_nettype none

module cordic_fixed_square_root
  import cfsr_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [30:0] square_in,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [23:0] root_out
);

  // stage 0: count, stage 1: seed, stages 2..8: CORDIC, stage 9: output
  localparam int unsigned NumStages = NumSteps + 3;

  typedef struct packed {
    logic [30:0] sq;
    logic [4:0]  lzc;
    logic        zero;
  } cfsr_norm_t;

  logic [NumStages-1:0] vld;   // valid bit per stage
  logic [NumStages-1:0] ld;    // stage register loads this cycle

  // Load chain: a stage takes a new beat when empty or when its beat moves on.
  always_comb begin
    ld[NumStages-1] = !vld[NumStages-1] || out_ready;
    for (int i = NumStages - 2; i >= 0; i--) begin
      ld[i] = !vld[i] || ld[i+1];
    end
  end

  assign in_ready = ld[0];

  // ---------------------------------------------------------------------
  // Stage 0: leading-zero count
  // ---------------------------------------------------------------------
  cfsr_norm_t norm;
  logic       norm_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_vld <= 1'b0;
    end else if (ld[0]) begin
      norm_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      norm.sq   <= square_in;
      norm.lzc  <= lead_zeros(square_in);
      norm.zero <= (square_in == 31'd0);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: even normalizing shift and CORDIC seed
  // ---------------------------------------------------------------------
  logic signed [5:0]       bits;      // 8 - lzc, range -23..7
  logic signed [4:0]       half;      // floor(bits/2), +1 when bits < 0
  logic [4:0]              neg_half;
  logic [5:0]              lsh;       // left shift, 2..22
  logic [2:0]              rsh;       // right shift, 0..6
  logic [24:0]             norm_v;
  logic signed [CordW-1:0] v_ext;
  cfsr_vec_t               seed_next;
  cfsr_vec_t               seed;
  logic                    seed_vld;

  always_comb begin
    bits     = 6'sd8 - signed'({1'b0, norm.lzc});
    half     = 5'(bits >>> 1) + {4'b0, bits[5]};
    neg_half = 5'd0 - half;
    lsh      = {neg_half, 1'b0};
    rsh      = {half[1:0], 1'b0};
    if (half[4]) begin
      norm_v = 25'(norm.sq << lsh);
    end else begin
      norm_v = 25'(norm.sq >> rsh);
    end
    v_ext          = CordW'({4'b0, norm_v});
    seed_next.x    = v_ext + RootMagic;
    seed_next.y    = v_ext - RootMagic;
    seed_next.half = half;
    seed_next.zero = norm.zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_vld <= 1'b0;
    end else if (ld[1]) begin
      seed_vld <= norm_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      seed <= seed_next;
    end
  end

  // ---------------------------------------------------------------------
  // Stages 2..8: one hyperbolic vectoring step each
  // ---------------------------------------------------------------------
  cfsr_vec_t             vec [NumSteps+1];
  logic [NumSteps:0]     vec_vld;

  assign vec[0]     = seed;
  assign vec_vld[0] = seed_vld;

  for (genvar k = 0; k < NumSteps; k++) begin : g_step
    cfsr_step #(
      .SHIFT (int'(step_shift(k)))
    ) u_step (
      .clk  (clk),
      .rst  (rst),
      .ld   (ld[k+2]),
      .vin  (vec_vld[k]),
      .din  (vec[k]),
      .vout (vec_vld[k+1]),
      .dout (vec[k+1])
    );
  end

  // ---------------------------------------------------------------------
  // Stage 9: denormalize, x >>> (6 - half), zero override
  // ---------------------------------------------------------------------
  cfsr_vec_t   last;
  logic [4:0]  out_sh;        // 3..17
  logic [23:0] root_next;

  assign last = vec[NumSteps];

  always_comb begin
    out_sh = 5'd6 - last.half;
    if (last.zero) begin
      root_next = 24'd0;
    end else begin
      root_next = 24'(last.x >>> out_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld[NumStages-1]) begin
      out_valid <= vec_vld[NumSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[NumStages-1]) begin
      root_out <= root_next;
    end
  end

  assign vld = {out_valid, vec_vld[NumSteps:1], seed_vld, norm_vld};

`ifndef SYNTHESIS
  // A free output slot must let the whole pipe advance.
  a_free_out_accepts: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("pipe stalled while output slot free");

  // Normalizing half-shift stays within -11..3 for nonzero beats.
  a_half_range: assert property (@(posedge clk) disable iff (rst)
    (seed_vld && !seed.zero) |-> (seed.half >= -5'sd11 && seed.half <= 5'sd3))
    else $error("normalizing shift out of range");

  // Converged x is non-negative for real inputs.
  a_x_positive: assert property (@(posedge clk) disable iff (rst)
    (vec_vld[NumSteps] && !last.zero) |-> !last.x[CordW-1])
    else $error("CORDIC x went negative");

  // Every root fits below 2^22.
  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (root_out[23:22] == 2'b00))
    else $error("root exceeds 22 bits");

  // An accepted zero beat is flagged in stage 0.
  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && square_in == 31'd0) |=> (norm_vld && norm.zero))
    else $error("zero input not flagged");
`endif

endmodule

`default_nettype wire

[tb/tb.sv]
`default_nettype none

module tb;
  import cfsr_pkg::*;

  // Watchdog. The slowest phases idle 84% on one side only; the limit
  // still leaves a wide margin over the whole run.
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandPerPhase = 470;
  // Pipeline depth at the top of the DUT is 10. Wait a bit more than that.
  localparam int unsigned TailCycles = 24;

  // Scoreboard: predicts the fixed-point square root of each accepted
  // operand and matches the results in order.
  class root_scoreboard;
    logic [23:0] root_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Normalize by an even shift, seed the hyperbolic vectoring pass,
    // run seven steps (shift 4 twice), then undo half the normalization.
    function logic [23:0] fixed_sqrt(logic [30:0] sq);
      int lz;
      int bits;
      int half;
      int s;
      longint v, x, y, xs, ys, r;
      if (sq == 0) begin
        return '0;
      end
      // Leading zeros in a 32-bit word; bit 31 is always zero.
      lz = 1;
      while (!sq[31-lz]) begin
        lz++;
      end
      bits = 8 - lz;
      if (bits >= 0) begin
        half = bits / 2;
        v = longint'(sq >> (2 * half));
      end else begin
        half = -((1 - bits) / 2) + 1;
        v = longint'(sq) << (-2 * half);
      end
      x = v + longint'(RootMagic);
      y = v - longint'(RootMagic);
      for (int k = 0; k < 7; k++) begin
        s = (k < 4) ? k + 1 : k;
        xs = x >>> s;
        ys = y >>> s;
        if (y >= 0) begin
          x = x - ys;
          y = y - xs;
        end else begin
          x = x + ys;
          y = y + xs;
        end
      end
      r = x >>> (6 - half);
      return r[23:0];
    endfunction

    function void note_square(logic [30:0] sq);
      root_q.push_back(fixed_sqrt(sq));
    endfunction

    function void check_root(logic [23:0] got);
      logic [23:0] want;
      if (root_q.size() == 0) begin
        $display("%0t: unexpected root_out beat: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = root_q.pop_front();
      if (got !== want) begin
        $display("%0t: root_out mismatch: expected %h, actual %h", $time, want, got);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return root_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [30:0] square_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [23:0] root_out;

  // Idle/stall rates in percent, changed per phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count = 0;

  root_scoreboard roots = new();

  cordic_fixed_square_root dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .square_in (square_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .root_out  (root_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog on cycles since time zero.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Result side. All TB drives are NBAs at posedge, so the values read
  // here are the ones from before the edge: that is the handshake.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      roots.check_root(root_out);
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // One operand beat. Optional idle cycles first. Valid is only lowered
  // when a gap is actually taken, so back-to-back beats keep it high.
  task automatic send_square(input logic [30:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    square_in <= val;
    do begin
      @(posedge clk);
    end while (!in_ready);
    roots.note_square(val);
  endtask

  // Park the operand side until every predicted root has come back.
  task automatic drain_roots();
    in_valid <= 1'b0;
    while (roots.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  // Random operands. Mostly spread over all magnitudes, so each
  // normalization shift (even, odd and negative bit counts) is hit.
  // The rest is full-range or tiny.
  function automatic logic [30:0] rand_square();
    int unsigned pick;
    int unsigned w;
    logic [30:0] raw;
    pick = $urandom_range(99);
    raw = 31'($urandom);
    if (pick < 60) begin
      w = $urandom_range(31, 1);
      return raw >> (31 - w);
    end else if (pick < 85) begin
      return raw;
    end else begin
      return 31'($urandom_range(16'h3FFF));
    end
  endfunction

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < RandPerPhase; n++) begin
      send_square(rand_square());
    end
    // Hold off the sender until the pipe is empty, then carry on.
    drain_roots();
  endtask

  logic [30:0] edge_vals[$] = '{
    31'h0000_0000,  // zero gives zero
    31'h0000_0001, 31'h0000_0002, 31'h0000_0003,  // smallest, bits very negative
    31'h0000_0080, 31'h0000_00FF, 31'h0000_0100,
    31'h0000_1000,  // 1.0
    31'h0000_2000,  // 2.0
    31'h0000_4000,  // 4.0
    31'h007F_FFFF,  // bits = -1
    31'h0080_0000,  // bits = 0
    31'h00FF_FFFF,
    31'h0100_0000,  // bits = 1, odd shift
    31'h0200_0000,  // bits = 2
    31'h0400_0000,
    31'h1555_5555,
    31'h2AAA_AAAA,
    31'h3FFF_FFFF,
    31'h4000_0000,  // top bit only
    31'h5555_5555,
    31'h7FFF_FFFF   // largest operand
  };

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners, no idling on either side.
    foreach (edge_vals[i]) begin
      send_square(edge_vals[i]);
    end
    drain_roots();

    run_phase(0, 0);    // full rate
    run_phase(84, 0);   // sparse operands
    run_phase(0, 84);   // result back-pressure
    run_phase(28, 28);  // mixed

    in_valid <= 1'b0;
    while (roots.pending() != 0) begin
      @(posedge clk);
    end
    // Catch any extra beats after the last expected one.
    repeat (TailCycles) @(posedge clk);

    if (roots.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
